/* hdl/scfd_pkg.sv */
// shared types, constants and byte-class functions for the string compare unit
package scfd_pkg;

  localparam int MAX_LEN_DEFAULT = 4096;
  localparam int CHAR_W          = 8;
  localparam int DIFF_W          = 9;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 8;

  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // register indexes of the configuration port
  localparam cfg_index_t REG_FOLD_CASE       = CFG_INDEX_W'(0);
  localparam cfg_index_t REG_DIRECTORY_ORDER = CFG_INDEX_W'(1);

  localparam char_t TERMINATOR = 8'h00;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_Z = 8'h5a;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_Z = 8'h7a;
  localparam char_t CH_DIGIT_0 = 8'h30;
  localparam char_t CH_DIGIT_9 = 8'h39;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_CR      = 8'h0d;
  localparam char_t CASE_BIT   = 8'h20;

  typedef struct packed {
    logic  side;
    char_t char_code;
  } item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] difference;
    logic                     overflow;
  } result_t;

  typedef enum logic {
    ST_LOAD,
    ST_WALK
  } state_t;

  // letters, digits and whitespace survive directory order
  function automatic logic is_kept(char_t c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
           (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic char_t fold(char_t c, logic fold_on);
    char_t r;
    r = c;
    if (fold_on && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

/* hdl/scfd_ram.sv */
// generic simple dual-port ram with registered read
module scfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/string_compare_fold_directory_unit.sv */
// string compare unit: loads two zero-ended strings, then walks them like strcmp
// string bytes are taken while loading; the transfer of the second terminator
// starts a walk over the compared positions and the bytes that directory order skips,
// after which the result stands in the output register
// throughput is set by the walk: per position a buffer read, a head capture and a compare
// reset (rst, synchronous): clears lengths, flags, pointers and the result valid flag;
// buffer contents are not cleared and need no clearing pass
module string_compare_fold_directory_unit
  import scfd_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN);

  state_t state, state_next;

  logic fold_case;
  logic directory_order;

  // load side bookkeeping, one entry per string
  logic [LW-1:0] len [2];
  logic          done [2];
  logic          truncated;

  // walk side: read pointer, read in flight, next byte for the compare
  logic [LW-1:0] pos [2];
  logic          pending [2];
  logic          head_valid [2];
  char_t         head [2];

  // buffer ports
  logic          we [2];
  logic          re [2];
  char_t         rdata [2];

  // per-side walk decisions
  logic          hit [2];
  logic          more [2];
  logic          set_head [2];
  char_t         head_value [2];
  logic          done_now [2];

  logic item_xfer;
  logic both_done;
  logic both_ready;
  logic finish;
  logic consume;
  logic slot_free;
  logic finish_xfer;
  logic [DIFF_W-1:0] diff;

  assign cfg_ready = 1'b1;
  assign item_xfer = item_valid && !item_stall;

  // writes happen only while loading and reads only while walking, so the
  // two never touch the same entry in one cycle
  for (genvar g = 0; g < 2; g++) begin : g_buf
    scfd_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_LEN)
    ) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (len[g][AW-1:0]),
      .wdata (item.char_code),
      .re    (re[g]),
      .raddr (pos[g][AW-1:0]),
      .rdata (rdata[g])
    );
  end

  // load and walk datapath decisions per side
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      we[g] = item_xfer && (item.side == g[0]) && !done[g] &&
              (item.char_code != TERMINATOR) && (len[g] != LEN_FULL);
      done_now[g] = done[g] ||
                    (item_xfer && (item.side == g[0]) && item.char_code == TERMINATOR);
      // a returning byte is taken unless directory order drops it
      hit[g]  = pending[g] && (!directory_order || is_kept(rdata[g]));
      more[g] = pos[g] != len[g];
      re[g]   = (state == ST_WALK) && !head_valid[g] && !hit[g] && more[g];
      // end of string reads as the terminator
      set_head[g]   = (state == ST_WALK) && !head_valid[g] && (hit[g] || !more[g]);
      head_value[g] = hit[g] ? fold(rdata[g], fold_case) : TERMINATOR;
    end
  end

  assign both_done  = done_now[0] && done_now[1];
  assign both_ready = head_valid[0] && head_valid[1];
  assign finish     = (state == ST_WALK) && both_ready &&
                      ((head[0] != head[1]) || (head[0] == TERMINATOR));
  assign consume    = (state == ST_WALK) && both_ready && !finish;
  assign slot_free  = !result_valid || !result_stall;
  assign finish_xfer = finish && slot_free;
  assign diff       = {1'b0, head[0]} - {1'b0, head[1]};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and channel control
  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    unique case (state)
      ST_LOAD: begin
        item_stall = 1'b0;
        if (item_xfer && both_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // result written only when the output register is free or being taken
        if (finish_xfer) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case       <= 1'b0;
      directory_order <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FOLD_CASE) begin
        fold_case <= cfg_data[0];
      end else if (cfg_index == REG_DIRECTORY_ORDER) begin
        directory_order <= cfg_data[0];
      end
    end
  end

  // load bookkeeping and walk pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      truncated <= 1'b0;
      for (int g = 0; g < 2; g++) begin
        len[g]        <= '0;
        done[g]       <= 1'b0;
        pos[g]        <= '0;
        pending[g]    <= 1'b0;
        head_valid[g] <= 1'b0;
      end
    end else begin
      if (item_xfer && !done[item.side] && item.char_code != TERMINATOR &&
          len[item.side] == LEN_FULL) begin
        truncated <= 1'b1;
      end
      for (int g = 0; g < 2; g++) begin
        if (we[g]) begin
          len[g] <= len[g] + LW'(1);
        end
        if (item_xfer) begin
          done[g] <= done_now[g];
        end
        // no reads are issued while loading, so this also clears it for the next walk
        pending[g] <= re[g];
        if (re[g]) begin
          pos[g] <= pos[g] + LW'(1);
        end
        if (set_head[g]) begin
          head_valid[g] <= 1'b1;
          head[g]       <= head_value[g];
        end else if (consume) begin
          head_valid[g] <= 1'b0;
        end
        // fresh walk for the next pair
        if (state == ST_LOAD) begin
          pos[g]        <= '0;
          head_valid[g] <= 1'b0;
        end
        if (finish_xfer) begin
          len[g]  <= '0;
          done[g] <= 1'b0;
        end
      end
      if (finish_xfer) begin
        truncated <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish_xfer) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_xfer) begin
      result.difference <= diff;
      result.overflow   <= truncated;
    end
  end

endmodule

/* hdl/scfd_checker.sv */
// port-level checks for the string compare unit, bound to the top level
module scfd_checker
  import scfd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // a byte difference never reaches -256
  a_diff_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.difference != 9'h100)
    else $error("difference out of range");

  // reset leaves no result behind
  a_reset_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // reset returns to loading
  a_reset_load: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("byte channel stalled after reset");

endmodule

bind string_compare_fold_directory_unit scfd_checker u_scfd_checker (.*);

/* tb/sv/strcmp_watch.sv */
// watches the byte, result and register channels and checks each comparison outcome
module strcmp_watch
  import scfd_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  item_t      item,
  input  logic       result_valid,
  input  logic       result_stall,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  output int         mismatches,
  output int         pending
);

  typedef char_t text_t[$];

  text_t   text_store [2];
  logic    ended [2];
  logic    dropped;
  logic    fold_on;
  logic    dir_on;
  result_t outcome_q[$];
  int      fail_count = 0;

  // bytes that take part in the comparison, after folding and filtering
  function automatic text_t squeeze(text_t raw, logic fold_en, logic dir_en);
    text_t key;
    char_t c;
    logic  upper;
    logic  kept;
    foreach (raw[i]) begin
      c = raw[i];
      upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
      kept = upper || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
             (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      if (!dir_en || kept) begin
        if (fold_en && upper) c = c + 8'd32;
        key.push_back(c);
      end
    end
    return key;
  endfunction

  // strcmp on the squeezed strings, end of string counting as byte zero
  function automatic int strcmp_diff(text_t a, text_t b);
    int n;
    int x;
    int y;
    n = (a.size() > b.size()) ? a.size() : b.size();
    for (int i = 0; i < n; i++) begin
      x = (i < a.size()) ? int'(a[i]) : 0;
      y = (i < b.size()) ? int'(b[i]) : 0;
      if (x != y) return x - y;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch_edge
    result_t want;
    result_t fresh;
    int      s;
    if (rst) begin
      text_store[0].delete();
      text_store[1].delete();
      ended[0] = 1'b0;
      ended[1] = 1'b0;
      dropped  = 1'b0;
      fold_on  = 1'b0;
      dir_on   = 1'b0;
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOLD_CASE:       fold_on = cfg_data[0];
          REG_DIRECTORY_ORDER: dir_on  = cfg_data[0];
          default: ;
        endcase
      end
      // results first, so a result never pairs with a string pair closed at this edge
      if (result_valid && !result_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no comparison pending: difference %0d overflow %0b",
                 $signed(result.difference), result.overflow);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (result.difference !== want.difference) begin
            $error("difference: expected %0d, got %0d",
                   $signed(want.difference), $signed(result.difference));
            fail_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        s = item.side ? 1 : 0;
        if (!ended[s]) begin
          if (item.char_code == TERMINATOR) ended[s] = 1'b1;
          else if (text_store[s].size() < MAX_LEN) text_store[s].push_back(item.char_code);
          else dropped = 1'b1;
        end
        if (ended[0] && ended[1]) begin
          fresh.difference = DIFF_W'(strcmp_diff(squeeze(text_store[0], fold_on, dir_on),
                                                 squeeze(text_store[1], fold_on, dir_on)));
          fresh.overflow = dropped;
          outcome_q.push_back(fresh);
          text_store[0].delete();
          text_store[1].delete();
          ended[0] = 1'b0;
          ended[1] = 1'b0;
          dropped  = 1'b0;
        end
      end
    end
    mismatches <= fail_count;
    pending    <= outcome_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// top of the string compare bench: stimulus, idling, register writes and the verdict
module tb_top;
  import scfd_pkg::*;

  localparam int BUF_LEN         = MAX_LEN_DEFAULT;
  localparam int SETTLE          = 16;   // margin after the last outcome, beyond the walk
  localparam int ITEMS_PER_PHASE = 340;

  typedef char_t text_t[$];

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index    = '0;
  cfg_data_t  cfg_data     = '0;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;

  string_compare_fold_directory_unit #(.MAX_LEN(BUF_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  strcmp_watch #(.MAX_LEN(BUF_LEN)) watch (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // result side back-pressure, redrawn every cycle at the current rate
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one byte transfer; valid stays high afterwards so back-to-back bytes need no gap
  task automatic send_byte(input logic s, input char_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{side: s, char_code: c};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // hold the byte channel until every outcome has arrived and the unit has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both registers written, in random order, with junk in the unused data bits;
  // junk also adds a write to an index past the two registers
  task automatic write_regs(input logic fold_val, input logic dir_val, input logic junk);
    cfg_index_t idx_q[$];
    cfg_data_t  val_q[$];
    int         junk_at;
    if ($urandom_range(1)) begin
      idx_q = '{REG_FOLD_CASE, REG_DIRECTORY_ORDER};
      val_q = '{{7'($urandom), fold_val}, {7'($urandom), dir_val}};
    end else begin
      idx_q = '{REG_DIRECTORY_ORDER, REG_FOLD_CASE};
      val_q = '{{7'($urandom), dir_val}, {7'($urandom), fold_val}};
    end
    if (junk) begin
      junk_at = int'($urandom_range(2));
      idx_q.insert(junk_at, cfg_index_t'($urandom_range(3, 2)));
      val_q.insert(junk_at, cfg_data_t'($urandom));
    end
    foreach (idx_q[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[i];
      cfg_data  <= (idx_q[i] == REG_FOLD_CASE || idx_q[i] == REG_DIRECTORY_ORDER) ?
                   val_q[i] : cfg_data_t'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // one string pair, bytes of the two sides interleaved at random;
  // spill bytes follow the terminator of the side that ends first and must be ignored
  // last_end: 0 or 1 picks the side whose terminator closes the pair, 2 picks at random
  task automatic run_pair(input text_t first_s, input text_t second_s, input text_t spill,
                          input int last_end);
    text_t lane [2];
    int    last_side;
    int    pick;
    last_side = (last_end == 2) ? int'($urandom_range(1)) : last_end;
    lane[0] = first_s;
    lane[1] = second_s;
    lane[1 - last_side].push_back(TERMINATOR);
    foreach (spill[i]) lane[1 - last_side].push_back(spill[i]);
    while (lane[0].size() + lane[1].size() > 0) begin
      if (lane[0].size() == 0) pick = 1;
      else if (lane[1].size() == 0) pick = 0;
      else pick = $urandom_range(1);
      send_byte(pick[0], lane[pick].pop_front());
    end
    send_byte(last_side[0], TERMINATOR);
    // now and then drain completely before the next pair
    if ($urandom_range(99) < 4) settle();
  endtask

  function automatic text_t bytes_of(string s);
    text_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(char_t'(s[i]));
    return q;
  endfunction

  // never zero: a zero would end the string early
  function automatic char_t rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return char_t'($urandom_range(CH_LOWER_Z, CH_LOWER_A));
    if (r < 50) return char_t'($urandom_range(CH_UPPER_Z, CH_UPPER_A));
    if (r < 60) return char_t'($urandom_range(CH_DIGIT_9, CH_DIGIT_0));
    if (r < 68) return $urandom_range(1) ? CH_SPACE : char_t'($urandom_range(CH_CR, CH_TAB));
    if (r < 82) return char_t'($urandom_range(126, 33));
    if (r < 92) return char_t'($urandom_range(255, 128));
    return char_t'($urandom_range(31, 1));
  endfunction

  function automatic text_t rand_text(int len);
    text_t q;
    repeat (len) q.push_back(rand_char());
    return q;
  endfunction

  // mostly a near copy so the walk goes deep; the rest unrelated noise
  function automatic text_t make_partner(text_t src);
    text_t q;
    int    r;
    char_t c;
    if ($urandom_range(99) < 15) return rand_text($urandom_range(12));
    foreach (src[i]) begin
      c = src[i];
      r = $urandom_range(99);
      if (r < 6) begin
        q.push_back(char_t'($urandom_range(47, 33)));   // punctuation slipped in
        q.push_back(c);
      end else if (r < 10) begin
        // byte left out
      end else if (r < 14) begin
        q.push_back(rand_char());
      end else if (r < 24 && ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                              (c >= CH_LOWER_A && c <= CH_LOWER_Z))) begin
        q.push_back(c ^ CASE_BIT);                       // other case of the same letter
      end else begin
        q.push_back(c);
      end
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) q.push_back(rand_char());
    end else if ($urandom_range(99) < 15 && q.size() > 0) begin
      q = q[0:$urandom_range(q.size() - 1)];
    end
    return q;
  endfunction

  // random pairs at the given idling rates, registers rewritten every dozen pairs
  task automatic random_phase(input int idle_send, input int idle_recv);
    int    target;
    int    pairs;
    int    len;
    text_t a;
    text_t spill;
    send_idle_pct   = idle_send;
    recv_stall_pct <= idle_recv;
    target = bytes_sent + ITEMS_PER_PHASE;
    pairs  = 0;
    while (bytes_sent < target) begin
      if (pairs % 12 == 0) begin
        settle();
        write_regs(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3) == 0);
      end
      len = ($urandom_range(99) < 5) ? $urandom_range(60, 13) : $urandom_range(12);
      a = rand_text(len);
      spill.delete();
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          spill.push_back($urandom_range(3) == 0 ? TERMINATOR : rand_char());
        end
      end
      if ($urandom_range(1)) run_pair(a, make_partner(a), spill, 2);
      else run_pair(make_partner(a), a, spill, 2);
      pairs++;
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, sender idling lightly and the result side stalling heavily
    send_idle_pct   = 18;
    recv_stall_pct <= 67;

    // reset settings: plain byte compare
    run_pair(bytes_of(""), bytes_of(""), bytes_of(""), 1);
    run_pair('{8'hff}, bytes_of(""), bytes_of(""), 0);        // largest positive difference
    run_pair(bytes_of(""), '{8'hff}, bytes_of(""), 1);        // largest negative difference
    run_pair(bytes_of("ab"), bytes_of("abc"), bytes_of(""), 2); // proper prefix is smaller
    // bytes, zero among them, after a terminator while the other side still loads
    run_pair(bytes_of("a"), bytes_of("a"), '{8'h80, TERMINATOR, 8'h7f}, 2);

    // folding and directory order together, with a write to an unused index
    settle();
    write_regs(1'b1, 1'b1, 1'b1);
    run_pair(bytes_of("Ab.C"), bytes_of("aBc"), bytes_of(""), 2);
    run_pair('{8'hc8, 8'h5a, 8'h09}, bytes_of("z\t"), bytes_of(""), 2);

    settle();
    write_regs(1'b1, 1'b0, 1'b0);
    run_pair(bytes_of("Z~"), bytes_of("z"), bytes_of(""), 2);

    settle();
    write_regs(1'b0, 1'b1, 1'b1);
    run_pair(bytes_of("Z#"), bytes_of("z"), bytes_of(""), 2);

    random_phase(18, 67);
    random_phase(67, 18);
    random_phase(0, 0);

    // everything sent: wait for the last outcomes and a quiet margin
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/scfd_pkg.sv
hdl/scfd_ram.sv
hdl/string_compare_fold_directory_unit.sv
hdl/scfd_checker.sv
tb/sv/strcmp_watch.sv
tb/sv/tb_top.sv
